FILE: rtl/core/stxd_pkg.sv
package stxd_pkg;

   // Width of the running payload counter
   localparam int unsigned COUNT_BITS = 16;

   // Fixed field widths
   localparam int unsigned BYTE_BITS     = 8;
   localparam int unsigned LEN_BITS      = 16;
   localparam int unsigned EVENT_BITS    = 3;
   localparam int unsigned PADDR_BITS    = 4;
   localparam int unsigned PDATA_BITS    = 32;
   localparam int unsigned REG_IDX_BITS  = 2;

   // Register indexes (byte address is 4 * index)
   localparam logic [REG_IDX_BITS-1:0] REG_MAX_LENGTH  = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_START_CODE  = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_END_CODE    = 2'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_ESCAPE_CODE = 2'd3;

   // Register reset values
   localparam logic [LEN_BITS-1:0]  MAX_LENGTH_RST  = 16'd4096;
   localparam logic [BYTE_BITS-1:0] START_CODE_RST  = 8'd2;
   localparam logic [BYTE_BITS-1:0] END_CODE_RST    = 8'd3;
   localparam logic [BYTE_BITS-1:0] ESCAPE_CODE_RST = 8'd27;

   // Framing states
   localparam logic [1:0] FM_SEARCH   = 2'd0;
   localparam logic [1:0] FM_EXPECT   = 2'd1;
   localparam logic [1:0] FM_ASSEMBLE = 2'd2;

   // Result event codes
   localparam logic [EVENT_BITS-1:0] EV_PAYLOAD    = 3'd0;
   localparam logic [EVENT_BITS-1:0] EV_END        = 3'd1;
   localparam logic [EVENT_BITS-1:0] EV_GARBAGE    = 3'd2;
   localparam logic [EVENT_BITS-1:0] EV_BADESC     = 3'd3;
   localparam logic [EVENT_BITS-1:0] EV_NAKEDSTART = 3'd4;
   localparam logic [EVENT_BITS-1:0] EV_OVERFLOW   = 3'd5;

   // Input mode codes
   localparam logic MODE_BYTE    = 1'b0;
   localparam logic MODE_RESTART = 1'b1;

   // Configuration registers as seen by the deframer
   typedef struct packed {
      logic [LEN_BITS-1:0]  max_length;
      logic [BYTE_BITS-1:0] start_code;
      logic [BYTE_BITS-1:0] end_code;
      logic [BYTE_BITS-1:0] escape_code;
   } cfg_type;

   // Framing state carried from item to item
   typedef struct packed {
      logic [1:0]            frame_mode;
      logic                  escape_pending;
      logic                  previous_was_escape;
      logic [COUNT_BITS-1:0] payload_count;
   } frame_state_type;

endpackage

FILE: rtl/core/stxd_if.sv
interface stxd_req_if;
   import stxd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [BYTE_BITS-1:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface stxd_rsp_if;
   import stxd_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [EVENT_BITS-1:0] event_res;
   logic [BYTE_BITS-1:0]  payload_byte;
   logic [LEN_BITS-1:0]   byte_count;

   modport source (output valid, output event_res, output payload_byte, output byte_count,
                   input ready);
   modport sink   (input valid, input event_res, input payload_byte, input byte_count,
                   output ready);
endinterface

FILE: rtl/core/stxd_csr.sv
module stxd_csr
   import stxd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [PDATA_BITS-1:0] pwdata,
   output logic [PDATA_BITS-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic                    wr_en;
   logic [REG_IDX_BITS-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[PADDR_BITS-1:2];

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MAX_LENGTH:  cfg_in.max_length  = pwdata[LEN_BITS-1:0];
            REG_START_CODE:  cfg_in.start_code  = pwdata[BYTE_BITS-1:0];
            REG_END_CODE:    cfg_in.end_code    = pwdata[BYTE_BITS-1:0];
            REG_ESCAPE_CODE: cfg_in.escape_code = pwdata[BYTE_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_length  <= MAX_LENGTH_RST;
         cfg_ff.start_code  <= START_CODE_RST;
         cfg_ff.end_code    <= END_CODE_RST;
         cfg_ff.escape_code <= ESCAPE_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_MAX_LENGTH:  prdata = PDATA_BITS'(cfg_ff.max_length);
         REG_START_CODE:  prdata = PDATA_BITS'(cfg_ff.start_code);
         REG_END_CODE:    prdata = PDATA_BITS'(cfg_ff.end_code);
         REG_ESCAPE_CODE: prdata = PDATA_BITS'(cfg_ff.escape_code);
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/stxd_engine.sv
module stxd_engine
   import stxd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   stxd_req_if.sink    req_chan,
   stxd_rsp_if.source  rsp_chan
);

   // input register
   logic                  in_valid_ff;
   logic                  in_mode_ff;
   logic [BYTE_BITS-1:0]  in_byte_ff;

   // framing state
   frame_state_type       st_ff;
   frame_state_type       st_in;

   // result register
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [EVENT_BITS-1:0] out_event_ff;
   logic [BYTE_BITS-1:0]  out_byte_ff;
   logic [LEN_BITS-1:0]   out_count_ff;

   // step results
   logic                  res_valid;
   logic [EVENT_BITS-1:0] res_event;
   logic [BYTE_BITS-1:0]  res_byte;
   logic [LEN_BITS-1:0]   res_count;

   logic                  advance;
   logic                  is_start;
   logic                  is_end;
   logic                  is_escape;
   logic                  naked_start;
   logic                  overflow;

   // handshake: the input stage moves on when the result slot is free or drains
   assign advance        = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | advance;

   assign is_start    = (in_byte_ff == cfg.start_code);
   assign is_end      = (in_byte_ff == cfg.end_code);
   assign is_escape   = (in_byte_ff == cfg.escape_code);
   assign naked_start = is_start & ~st_ff.previous_was_escape;
   assign overflow    = (st_ff.payload_count >= COUNT_BITS'(0) + cfg.max_length) |
                        (st_ff.payload_count == {COUNT_BITS{1'b1}});

   // one framing step on the registered byte
   always_comb begin
      st_in     = st_ff;
      res_valid = 1'b0;
      res_event = EV_PAYLOAD;
      res_byte  = '0;
      res_count = '0;
      if (in_mode_ff == MODE_RESTART) begin
         st_in.frame_mode          = FM_SEARCH;
         st_in.escape_pending      = 1'b0;
         st_in.previous_was_escape = 1'b0;
         st_in.payload_count       = '0;
      end else begin
         st_in.previous_was_escape = is_escape;
         unique case (st_ff.frame_mode)
            FM_EXPECT: begin
               if (naked_start) begin
                  st_in.payload_count = '0;
                  st_in.frame_mode    = FM_ASSEMBLE;
               end else begin
                  st_in.frame_mode     = FM_SEARCH;
                  st_in.escape_pending = 1'b0;
                  st_in.payload_count  = '0;
                  res_valid            = 1'b1;
                  res_event            = EV_GARBAGE;
               end
            end
            FM_ASSEMBLE: begin
               priority if (st_ff.escape_pending &&
                            !(is_start || is_end || is_escape)) begin
                  // escaped byte that is not a framing code
                  st_in.frame_mode     = FM_SEARCH;
                  st_in.escape_pending = 1'b0;
                  st_in.payload_count  = '0;
                  res_valid            = 1'b1;
                  res_event            = EV_BADESC;
               end else if (!st_ff.escape_pending && is_end) begin
                  st_in.payload_count = '0;
                  st_in.frame_mode    = FM_EXPECT;
                  res_valid           = 1'b1;
                  res_event           = EV_END;
                  res_count           = LEN_BITS'(st_ff.payload_count);
               end else if (!st_ff.escape_pending && is_escape) begin
                  st_in.escape_pending = 1'b1;
               end else if (!st_ff.escape_pending && is_start) begin
                  st_in.frame_mode     = FM_SEARCH;
                  st_in.payload_count  = '0;
                  res_valid            = 1'b1;
                  res_event            = EV_NAKEDSTART;
               end else begin
                  // literal payload byte, plain or escaped
                  st_in.escape_pending = 1'b0;
                  res_valid            = 1'b1;
                  if (overflow) begin
                     st_in.frame_mode    = FM_SEARCH;
                     st_in.payload_count = '0;
                     res_event           = EV_OVERFLOW;
                     res_count           = cfg.max_length;
                  end else begin
                     st_in.payload_count = st_ff.payload_count + COUNT_BITS'(1);
                     res_event           = EV_PAYLOAD;
                     res_byte            = in_byte_ff;
                     res_count           = LEN_BITS'(st_ff.payload_count);
                  end
               end
            end
            default: begin
               // searching, also the unused mode code
               st_in.frame_mode = FM_SEARCH;
               if (naked_start) begin
                  st_in.payload_count  = '0;
                  st_in.escape_pending = 1'b0;
                  st_in.frame_mode     = FM_ASSEMBLE;
               end
            end
         endcase
      end
   end

   // result slot: filled on a step that produces a result, emptied on transfer
   always_comb begin
      out_valid_in = out_valid_ff & ~rsp_chan.ready;
      if (advance && res_valid) begin
         out_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         out_valid_ff                <= 1'b0;
         st_ff.frame_mode            <= FM_SEARCH;
         st_ff.escape_pending        <= 1'b0;
         st_ff.previous_was_escape   <= 1'b0;
         st_ff.payload_count         <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_mode_ff <= req_chan.mode;
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance && res_valid) begin
         out_event_ff <= res_event;
         out_byte_ff  <= res_byte;
         out_count_ff <= res_count;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.event_res    = out_event_ff;
   assign rsp_chan.payload_byte = out_byte_ff;
   assign rsp_chan.byte_count   = out_count_ff;

endmodule

FILE: rtl/core/stx_etx_escape_deframer_core.sv
// STX/ETX byte-stuffing deframer.
// req_chan carries one item per transfer: mode 0 with a received rx_byte, or
// mode 1 for a link restart, which drops back to hunting for a start code.
// rsp_chan carries zero or one result per item: event_res, payload_byte
// (unescaped byte for payload events) and byte_count (payload index, message
// length at end of message, max_length on overflow).
// The APB port holds max_length, start_code, end_code and escape_code at
// byte addresses 0, 4, 8 and 12; write them only while the block is idle.
// Throughput: one item per clock while rsp_chan does not stall. An item is
// registered in the input register at its transfer, then its framing step
// updates the framing state and loads any result into the result register,
// which drives rsp_chan. The framing-state feedback (one step per cycle) sets that rate.
// When rsp_chan stalls, one more item is still taken into the input
// register; req_chan.ready then drops until the waiting result leaves.
// Reset (synchronous, active high) empties both stages, returns framing to
// searching with cleared flags and count, and loads the register defaults.
module stx_etx_escape_deframer_core
   import stxd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   stxd_req_if.sink              req_chan,
   stxd_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_BITS-1:0] paddr,
   input  logic [PDATA_BITS-1:0] pwdata,
   output logic [PDATA_BITS-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;

   // configuration registers
   stxd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // deframing datapath
   stxd_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import stxd_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;

   // One expected deframer result
   typedef struct packed {
      logic [EVENT_BITS-1:0] kind;
      logic [BYTE_BITS-1:0]  data;
      logic [LEN_BITS-1:0]   count;
   } frame_event_type;

   // Tracks the framing state and the results each transfer should produce
   class frame_event_board;
      logic [LEN_BITS-1:0]   max_len;
      logic [BYTE_BITS-1:0]  start_byte;
      logic [BYTE_BITS-1:0]  end_byte;
      logic [BYTE_BITS-1:0]  esc_byte;
      logic [1:0]            frame;
      bit                    esc_pending;
      bit                    last_was_esc;
      logic [COUNT_BITS-1:0] byte_idx;
      frame_event_type       pending[$];
      int                    fail_count;

      function new();
         max_len      = MAX_LENGTH_RST;
         start_byte   = START_CODE_RST;
         end_byte     = END_CODE_RST;
         esc_byte     = ESCAPE_CODE_RST;
         frame        = FM_SEARCH;
         esc_pending  = 1'b0;
         last_was_esc = 1'b0;
         byte_idx     = '0;
         fail_count   = 0;
      endfunction

      function void flag(string msg);
         fail_count++;
         if (fail_count <= 10) $display("%0t ERROR %s", $time, msg);
      endfunction

      function void set_reg(logic [REG_IDX_BITS-1:0] idx, logic [PDATA_BITS-1:0] value);
         case (idx)
            REG_MAX_LENGTH:  max_len    = value[LEN_BITS-1:0];
            REG_START_CODE:  start_byte = value[BYTE_BITS-1:0];
            REG_END_CODE:    end_byte   = value[BYTE_BITS-1:0];
            REG_ESCAPE_CODE: esc_byte   = value[BYTE_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [PDATA_BITS-1:0] reg_value(logic [REG_IDX_BITS-1:0] idx);
         case (idx)
            REG_MAX_LENGTH: return PDATA_BITS'(max_len);
            REG_START_CODE: return PDATA_BITS'(start_byte);
            REG_END_CODE:   return PDATA_BITS'(end_byte);
            default:        return PDATA_BITS'(esc_byte);
         endcase
      endfunction

      function void post(logic [EVENT_BITS-1:0] kind, logic [BYTE_BITS-1:0] data,
                         logic [LEN_BITS-1:0] count);
         frame_event_type item;
         item.kind  = kind;
         item.data  = data;
         item.count = count;
         pending.push_back(item);
      endfunction

      // Error: drop back to hunting for a start code
      function void resync(logic [EVENT_BITS-1:0] kind, logic [LEN_BITS-1:0] count);
         frame       = FM_SEARCH;
         esc_pending = 1'b0;
         byte_idx    = '0;
         post(kind, '0, count);
      endfunction

      // Payload byte, unless the message is already full
      function void store(logic [BYTE_BITS-1:0] b);
         if (byte_idx >= max_len || byte_idx == {COUNT_BITS{1'b1}}) begin
            resync(EV_OVERFLOW, max_len);
         end else begin
            post(EV_PAYLOAD, b, LEN_BITS'(byte_idx));
            byte_idx = byte_idx + 1'b1;
         end
      endfunction

      function void note_item(logic mode, logic [BYTE_BITS-1:0] b);
         bit prev;
         if (mode == MODE_RESTART) begin
            frame        = FM_SEARCH;
            esc_pending  = 1'b0;
            last_was_esc = 1'b0;
            byte_idx     = '0;
            return;
         end
         prev         = last_was_esc;
         last_was_esc = (b == esc_byte);
         case (frame)
            FM_EXPECT: begin
               if (b == start_byte && !prev) begin
                  byte_idx = '0;
                  frame    = FM_ASSEMBLE;
               end else begin
                  resync(EV_GARBAGE, '0);
               end
            end
            FM_ASSEMBLE: begin
               // escaped byte skips the end-code test
               if (esc_pending) begin
                  esc_pending = 1'b0;
                  if (b != start_byte && b != end_byte && b != esc_byte)
                     resync(EV_BADESC, '0);
                  else
                     store(b);
               end else if (b == end_byte) begin
                  post(EV_END, '0, LEN_BITS'(byte_idx));
                  byte_idx = '0;
                  frame    = FM_EXPECT;
               end else if (b == esc_byte) begin
                  esc_pending = 1'b1;
               end else if (b == start_byte) begin
                  resync(EV_NAKEDSTART, '0);
               end else begin
                  store(b);
               end
            end
            default: begin
               frame = FM_SEARCH;
               if (b == start_byte && !prev) begin
                  byte_idx    = '0;
                  esc_pending = 1'b0;
                  frame       = FM_ASSEMBLE;
               end
            end
         endcase
      endfunction

      function void check_event(logic [EVENT_BITS-1:0] kind, logic [BYTE_BITS-1:0] data,
                                logic [LEN_BITS-1:0] count);
         frame_event_type exp;
         if (pending.size() == 0) begin
            flag($sformatf("unexpected result: event %0d byte %02h count %0d",
                           kind, data, count));
            return;
         end
         exp = pending.pop_front();
         if (kind !== exp.kind || data !== exp.data || count !== exp.count)
            flag($sformatf({"result mismatch: expected event %0d byte %02h count %0d,",
                            " got event %0d byte %02h count %0d"},
                           exp.kind, exp.data, exp.count, kind, data, count));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [PADDR_BITS-1:0] paddr;
   logic [PDATA_BITS-1:0] pwdata;
   logic [PDATA_BITS-1:0] prdata;
   logic                  pready;

   stxd_req_if req_chan ();
   stxd_rsp_if rsp_chan ();

   frame_event_board board = new();

   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int long_hold    = 0;
   int items_sent   = 0;
   int quiet_cycles = 0;

   stx_etx_escape_deframer_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: long hold-off when requested, random stalls otherwise
   always @(negedge clock) begin
      if (long_hold > 0) begin
         rsp_chan.ready <= 1'b0;
         long_hold--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_event(rsp_chan.event_res, rsp_chan.payload_byte, rsp_chan.byte_count);
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("stx_etx_escape_deframer_core verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One input transfer, with random idle cycles ahead of it
   task automatic send_item(input logic mode, input logic [BYTE_BITS-1:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.mode    <= mode;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      board.note_item(mode, b);
      items_sent++;
      @(negedge clock);
   endtask

   // Stop offering and wait until the block has gone quiet
   task automatic drain_pipe();
      req_chan.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      @(negedge clock);
   endtask

   // APB write followed by a read back of the same register
   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx,
                            input logic [PDATA_BITS-1:0] value);
      logic [PDATA_BITS-1:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_BITS'({idx, 2'b00});
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.set_reg(idx, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== board.reg_value(idx))
         board.flag($sformatf("register %0d read %08h, expected %08h",
                              idx, readback, board.reg_value(idx)));
   endtask

   // Mostly well-formed message with random content, plus some line noise
   task automatic send_frame();
      int len;
      int roll;
      int i;
      logic [BYTE_BITS-1:0] b;
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
      if ($urandom_range(9) == 0) send_item(MODE_BYTE, BYTE_BITS'($urandom));
      if ($urandom_range(29) == 0) send_item(MODE_RESTART, BYTE_BITS'($urandom));
      send_item(MODE_BYTE, board.start_byte);
      for (i = 0; i < len; i++) begin
         roll = $urandom_range(99);
         if (roll < 3) begin
            // escape followed by an arbitrary byte
            send_item(MODE_BYTE, board.esc_byte);
            send_item(MODE_BYTE, BYTE_BITS'($urandom));
         end else if (roll < 5) begin
            send_item(MODE_BYTE, board.start_byte);
         end else if (roll < 6) begin
            send_item(MODE_RESTART, BYTE_BITS'($urandom));
         end else begin
            if (roll < 30) begin
               case ($urandom_range(2))
                  0:       b = board.start_byte;
                  1:       b = board.end_byte;
                  default: b = board.esc_byte;
               endcase
            end else begin
               b = BYTE_BITS'($urandom);
            end
            if (b == board.start_byte || b == board.end_byte || b == board.esc_byte)
               send_item(MODE_BYTE, board.esc_byte);
            send_item(MODE_BYTE, b);
         end
      end
      if ($urandom_range(19) != 0) send_item(MODE_BYTE, board.end_byte);
   endtask

   initial begin
      int phase;
      int budget;
      logic [LEN_BITS-1:0]  cfg_len;
      logic [BYTE_BITS-1:0] cfg_s;
      logic [BYTE_BITS-1:0] cfg_e;
      logic [BYTE_BITS-1:0] cfg_x;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.mode    = MODE_BYTE;
      req_chan.rx_byte = '0;
      rsp_chan.ready   = 1'b0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed checks with the reset framing codes
      send_item(MODE_RESTART, 8'hA5);
      send_item(MODE_BYTE, 8'h55);               // dropped while searching
      send_item(MODE_BYTE, ESCAPE_CODE_RST);     // escaped start is not a start
      send_item(MODE_BYTE, START_CODE_RST);
      send_item(MODE_BYTE, START_CODE_RST);      // real start
      send_item(MODE_BYTE, 8'h00);
      send_item(MODE_BYTE, 8'hFF);
      send_item(MODE_BYTE, ESCAPE_CODE_RST);     // escaped escape, end and start
      send_item(MODE_BYTE, ESCAPE_CODE_RST);
      send_item(MODE_BYTE, ESCAPE_CODE_RST);
      send_item(MODE_BYTE, END_CODE_RST);
      send_item(MODE_BYTE, ESCAPE_CODE_RST);
      send_item(MODE_BYTE, START_CODE_RST);
      send_item(MODE_BYTE, END_CODE_RST);        // end, length five
      send_item(MODE_BYTE, START_CODE_RST);
      send_item(MODE_BYTE, ESCAPE_CODE_RST);     // bad escape
      send_item(MODE_BYTE, 8'h41);
      send_item(MODE_BYTE, START_CODE_RST);
      send_item(MODE_BYTE, 8'h10);
      send_item(MODE_BYTE, START_CODE_RST);      // unescaped start
      send_item(MODE_BYTE, START_CODE_RST);
      send_item(MODE_BYTE, 8'h20);
      send_item(MODE_RESTART, 8'h5A);            // restart mid-message
      send_item(MODE_BYTE, 8'h30);
      send_item(MODE_BYTE, START_CODE_RST);
      send_item(MODE_BYTE, END_CODE_RST);        // empty message
      send_item(MODE_BYTE, 8'h77);               // garbage between messages
      drain_pipe();

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               cfg_len = MAX_LENGTH_RST;
               cfg_s   = START_CODE_RST;
               cfg_e   = END_CODE_RST;
               cfg_x   = ESCAPE_CODE_RST;
            end
            1: begin
               cfg_len = 16'd1;
               cfg_s   = 8'h00;
               cfg_e   = 8'hFF;
               cfg_x   = 8'h80;
            end
            2: begin
               cfg_len = 16'hFFFF;
               cfg_s   = 8'hFF;
               cfg_e   = 8'h00;
               cfg_x   = 8'h01;
            end
            3: begin
               cfg_len = 16'd0;
               cfg_s   = 8'h7E;
               cfg_e   = 8'h7F;
               cfg_x   = 8'h7D;
            end
            4: begin
               // start and end share one code
               cfg_len = LEN_BITS'($urandom_range(16, 2));
               cfg_s   = BYTE_BITS'($urandom);
               cfg_e   = cfg_s;
               cfg_x   = cfg_s ^ 8'h5A;
            end
            5: begin
               // start and escape share one code
               cfg_len = LEN_BITS'($urandom_range(30, 1));
               cfg_s   = BYTE_BITS'($urandom);
               cfg_x   = cfg_s;
               cfg_e   = ~cfg_s;
            end
            6: begin
               // end and escape share one code
               cfg_len = LEN_BITS'($urandom_range(30, 1));
               cfg_e   = BYTE_BITS'($urandom);
               cfg_x   = cfg_e;
               cfg_s   = cfg_e + 8'd1;
            end
            default: begin
               cfg_len = ($urandom_range(1) == 0) ? LEN_BITS'($urandom_range(20, 1))
                                                  : LEN_BITS'($urandom_range(65535, 1));
               cfg_s   = BYTE_BITS'($urandom);
               cfg_e   = BYTE_BITS'($urandom);
               cfg_x   = BYTE_BITS'($urandom);
            end
         endcase
         csr_write(REG_MAX_LENGTH, {16'($urandom), cfg_len});
         csr_write(REG_START_CODE, {24'($urandom), cfg_s});
         csr_write(REG_END_CODE, {24'($urandom), cfg_e});
         csr_write(REG_ESCAPE_CODE, {24'($urandom), cfg_x});

         case (phase % 4)
            0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1:       begin tx_idle_pct = 69; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 69; end
            default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
         endcase

         // overflow on the second payload byte
         if (phase == 1) begin
            send_item(MODE_BYTE, cfg_s);
            send_item(MODE_BYTE, 8'h11);
            send_item(MODE_BYTE, 8'h22);
         end
         // hold the receiver off so the block backs up into its input
         if (phase == 2) begin
            @(posedge clock);
            long_hold = LONG_HOLD;
            @(negedge clock);
         end

         budget = items_sent + ((phase == 3) ? 40 : 135);
         while (items_sent < budget) send_frame();
         drain_pipe();
      end

      if (board.pending.size() != 0)
         board.flag($sformatf("%0d expected results never arrived", board.pending.size()));
      if (board.fail_count == 0)
         $display("stx_etx_escape_deframer_core verification clean");
      else
         $display("stx_etx_escape_deframer_core verification failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/stxd_pkg.sv
rtl/core/stxd_if.sv
rtl/core/stxd_csr.sv
rtl/core/stxd_engine.sv
rtl/core/stx_etx_escape_deframer_core.sv
verif/tb_top.sv
